// ===== rtl/log_byte_ring_buffer_defines.svh =====
// Assertion macros for the log byte ring buffer checker.
`ifndef LOG_BYTE_RING_BUFFER_DEFINES_SVH
`define LOG_BYTE_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LBRB_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbrb check failed");

// Next-cycle implication, disabled during reset.
`define LBRB_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbrb check failed");

`endif

// ===== rtl/lbrb_pkg.sv =====
// Shared types and constants for the log byte ring buffer.
package lbrb_pkg;

  localparam int OP_W    = 3;
  localparam int LEN_W   = 11;
  localparam int LEVEL_W = 4;
  localparam int COUNT_W = 32;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [7:0]         byte_t;

  localparam op_t OP_PUT       = 3'd0;
  localparam op_t OP_MSG       = 3'd1;
  localparam op_t OP_READ      = 3'd2;
  localparam op_t OP_READ_CRLF = 3'd3;
  localparam op_t OP_PEEK      = 3'd4;
  localparam op_t OP_CLEAR     = 3'd5;

  localparam byte_t CHAR_CR = 8'h0D;
  localparam byte_t CHAR_LF = 8'h0A;
  localparam byte_t MARKER  = 8'hFF;

endpackage

// ===== rtl/log_byte_ring_buffer.sv =====
// Log byte ring buffer: top level with the byte store and its sequencer.
//
// Writes (put char, message byte) keep busy low and strobe their result in
// the following cycle, as does a clear, which then sweeps the store as
// below, and a read of an empty store. Other reads and history peeks pass
// through the registered byte store read and the S_READ state before the
// result register; a read that expands newline to CR LF strobes a CR result,
// then an LF result. Results cannot be held off: result_strobe is high for a
// single cycle per result. After reset and after every clear the store is
// swept to zero, one entry per cycle, over all 2^LOG_DEPTH entries with
// busy high; level threshold writes are still taken. held_bytes and
// overflow_total always show the current state.
module log_byte_ring_buffer #(
  parameter int LOG_DEPTH = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  lbrb_pkg::op_t         operation,
  input  lbrb_pkg::byte_t       write_data,
  input  logic                  first_of_message,
  input  lbrb_pkg::len_t        message_length,
  input  lbrb_pkg::level_t      current_level,
  input  lbrb_pkg::len_t        history_offset,
  input  logic                  cfg_write,
  input  lbrb_pkg::level_t      cfg_data,
  output logic                  result_strobe,
  output lbrb_pkg::byte_t       read_data,
  output logic                  read_valid,
  output logic                  last,
  output logic [LOG_DEPTH:0]    held_bytes,
  output lbrb_pkg::count_t      overflow_total,
  output logic                  write_accepted
);

  localparam int DEPTH = 1 << LOG_DEPTH;
  localparam int PW    = LOG_DEPTH + 1;
  localparam int LW    = lbrb_pkg::LEN_W;
  localparam int CW    = (PW > LW) ? PW : LW;
  localparam logic [PW-1:0] FULL_COUNT = PW'(DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_NL    = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  logic [1:0]            state, state_next;
  logic [PW-1:0]         wp, wp_next, rp, rp_next;
  logic                  message_kept, kept_next;
  lbrb_pkg::count_t      overflow_count, overflow_next;
  lbrb_pkg::level_t      level_threshold;
  logic [LOG_DEPTH-1:0]  sweep, sweep_next;
  logic                  crlf_op, crlf_next;

  lbrb_pkg::byte_t       ring [DEPTH];
  lbrb_pkg::byte_t       mem_q;
  logic                  mem_we, mem_re;
  logic [LOG_DEPTH-1:0]  mem_waddr, mem_raddr;
  lbrb_pkg::byte_t       mem_wdata;

  logic                  res_load, res_valid, res_last, res_acc;
  lbrb_pkg::byte_t       res_data;

  logic [PW-1:0]         held, room, rp_adj;
  logic                  full, empty, fits, go;
  logic                  acc, ovf;
  lbrb_pkg::len_t        size;
  logic [CW-1:0]         peek_diff;

  assign held      = wp - rp;
  assign full      = held[LOG_DEPTH];
  assign empty     = (held == '0);
  assign room      = FULL_COUNT - held;
  assign size      = (operation == lbrb_pkg::OP_MSG) ? message_length : LW'(1);
  assign fits      = CW'(room) > CW'(size);
  assign rp_adj    = full ? rp + PW'(1) : rp;
  assign peek_diff = CW'(wp) - CW'(history_offset);
  assign busy      = (state != S_IDLE);
  assign go        = start && !busy;

  assign held_bytes     = held;
  assign overflow_total = overflow_count;

  // Write decision for put char and message bytes.
  always_comb begin
    acc       = 1'b0;
    ovf       = 1'b0;
    kept_next = message_kept;
    case (operation)
      lbrb_pkg::OP_PUT: begin
        if (current_level >= level_threshold) begin
          acc = fits;
          ovf = !fits;
        end
      end
      lbrb_pkg::OP_MSG: begin
        if (first_of_message) begin
          acc       = fits;
          ovf       = !fits;
          kept_next = fits;
        end else if (message_kept) begin
          acc       = !full;
          kept_next = !full;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next    = state;
    wp_next       = wp;
    rp_next       = rp;
    overflow_next = overflow_count;
    sweep_next    = sweep;
    crlf_next     = crlf_op;
    mem_we        = 1'b0;
    mem_waddr     = wp[LOG_DEPTH-1:0];
    mem_wdata     = acc ? write_data : lbrb_pkg::MARKER;
    mem_re        = 1'b0;
    mem_raddr     = rp_adj[LOG_DEPTH-1:0];
    res_load      = 1'b0;
    res_data      = '0;
    res_valid     = 1'b0;
    res_last      = 1'b1;
    res_acc       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (go) begin
          case (operation) inside
            lbrb_pkg::OP_PUT, lbrb_pkg::OP_MSG: begin
              mem_we   = acc || (ovf && !full);
              if (mem_we) begin
                wp_next = wp + PW'(1);
              end
              if (ovf) begin
                overflow_next = overflow_count + 32'd1;
              end
              res_load = 1'b1;
              res_acc  = acc;
            end
            lbrb_pkg::OP_READ, lbrb_pkg::OP_READ_CRLF: begin
              if (empty) begin
                res_load = 1'b1;
              end else begin
                mem_re     = 1'b1;
                rp_next    = rp_adj + PW'(1);
                crlf_next  = (operation == lbrb_pkg::OP_READ_CRLF);
                state_next = S_READ;
              end
            end
            lbrb_pkg::OP_PEEK: begin
              mem_re     = 1'b1;
              mem_raddr  = peek_diff[LOG_DEPTH-1:0];
              crlf_next  = 1'b0;
              state_next = S_READ;
            end
            lbrb_pkg::OP_CLEAR: begin
              wp_next    = '0;
              rp_next    = '0;
              sweep_next = '0;
              state_next = S_CLEAR;
              res_load   = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res_load  = 1'b1;
        res_valid = 1'b1;
        if (crlf_op && mem_q == lbrb_pkg::CHAR_LF) begin
          res_data   = lbrb_pkg::CHAR_CR;
          res_last   = 1'b0;
          state_next = S_NL;
        end else begin
          res_data   = mem_q;
          state_next = S_IDLE;
        end
      end
      S_NL: begin
        res_load   = 1'b1;
        res_valid  = 1'b1;
        res_data   = lbrb_pkg::CHAR_LF;
        state_next = S_IDLE;
      end
      S_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = sweep;
        mem_wdata  = '0;
        sweep_next = sweep + LOG_DEPTH'(1);
        if (sweep == '1) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      wp              <= '0;
      rp              <= '0;
      overflow_count  <= '0;
      message_kept    <= 1'b0;
      level_threshold <= '0;
      sweep           <= '0;
      crlf_op         <= 1'b0;
      result_strobe   <= 1'b0;
    end else begin
      state          <= state_next;
      wp             <= wp_next;
      rp             <= rp_next;
      overflow_count <= overflow_next;
      sweep          <= sweep_next;
      crlf_op        <= crlf_next;
      result_strobe  <= res_load;
      if (go && (operation == lbrb_pkg::OP_PUT || operation == lbrb_pkg::OP_MSG)) begin
        message_kept <= kept_next;
      end else if (go && operation == lbrb_pkg::OP_CLEAR) begin
        message_kept <= 1'b0;
      end
      if (cfg_write) begin
        level_threshold <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      read_data      <= res_data;
      read_valid     <= res_valid;
      last           <= res_last;
      write_accepted <= res_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= ring[mem_raddr];
    end
  end

endmodule

// ===== rtl/lbrb_checker.sv =====
// Port-level checks for the log byte ring buffer, bound to the top level.
`include "log_byte_ring_buffer_defines.svh"

module lbrb_checker #(
  parameter int LOG_DEPTH = 10
) (
  input logic               clk,
  input logic               rst,
  input logic               result_strobe,
  input lbrb_pkg::byte_t    read_data,
  input logic               read_valid,
  input logic               last,
  input logic [LOG_DEPTH:0] held_bytes,
  input logic               write_accepted
);

  localparam logic [LOG_DEPTH:0] HELD_MAX = (LOG_DEPTH + 1)'(1 << LOG_DEPTH);

  logic cr_out, lf_out;

  assign cr_out = read_valid && read_data == lbrb_pkg::CHAR_CR;
  assign lf_out = result_strobe && last && read_valid && read_data == lbrb_pkg::CHAR_LF;

  `LBRB_NEXT(cr_then_lf, clk, rst, result_strobe && !last, lf_out)
  `LBRB_IMPLIES(early_is_cr, clk, rst, result_strobe && !last, cr_out)
  `LBRB_IMPLIES(empty_result_zero, clk, rst, result_strobe && !read_valid, read_data == 8'h00)
  `LBRB_IMPLIES(write_has_no_byte, clk, rst, result_strobe && write_accepted, !read_valid && last)
  `LBRB_IMPLIES(held_in_range, clk, rst, result_strobe, held_bytes <= HELD_MAX)

endmodule

bind log_byte_ring_buffer lbrb_checker #(.LOG_DEPTH(LOG_DEPTH)) u_lbrb_checker (.*);

// ===== tb/log_byte_ring_buffer_tb.sv =====
// Self-checking testbench for the log byte ring buffer against a shadow ring.

class ring_shadow #(int LOGD = 10);
  localparam int DEPTH = 1 << LOGD;

  typedef struct packed {
    lbrb_pkg::byte_t  data;
    logic             valid;
    logic             tail;
    logic [LOGD:0]    held;
    lbrb_pkg::count_t overflows;
    logic             accepted;
  } ring_result_t;

  lbrb_pkg::byte_t  ring_mem [DEPTH];
  logic [LOGD:0]    wr_ptr;
  logic [LOGD:0]    rd_ptr;
  lbrb_pkg::count_t overflows;
  bit               msg_kept;
  lbrb_pkg::level_t threshold;
  ring_result_t     due_results [$];
  int               errors;

  function new();
    wipe();
    overflows = '0;
    threshold = '0;
    errors    = 0;
  endfunction

  function void wipe();
    foreach (ring_mem[i]) ring_mem[i] = '0;
    wr_ptr   = '0;
    rd_ptr   = '0;
    msg_kept = 1'b0;
  endfunction

  function logic [LOGD:0] held_now();
    return wr_ptr - rd_ptr;
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  function void set_threshold(lbrb_pkg::level_t v);
    threshold = v;
  endfunction

  function void append(lbrb_pkg::byte_t b);
    ring_mem[wr_ptr[LOGD-1:0]] = b;
    wr_ptr = wr_ptr + 1'b1;
  endfunction

  function void count_overflow();
    overflows = overflows + 1;
    if (held_now() < DEPTH) append(lbrb_pkg::MARKER);
  endfunction

  function bit room_write(lbrb_pkg::byte_t b, int size);
    if (DEPTH - int'(held_now()) > size) begin
      append(b);
      return 1'b1;
    end
    count_overflow();
    return 1'b0;
  endfunction

  function void push(lbrb_pkg::byte_t d, logic v, logic t, logic a);
    ring_result_t r;
    r.data      = d;
    r.valid     = v;
    r.tail      = t;
    r.held      = held_now();
    r.overflows = overflows;
    r.accepted  = a;
    due_results.push_back(r);
  endfunction

  function void take_item(lbrb_pkg::op_t op, lbrb_pkg::byte_t d, logic first,
                          lbrb_pkg::len_t len, lbrb_pkg::level_t lv, lbrb_pkg::len_t off);
    logic            acc;
    lbrb_pkg::byte_t c;
    logic [31:0]     peek_at;
    acc = 1'b0;
    case (op)
      lbrb_pkg::OP_PUT: begin
        if (lv >= threshold) acc = room_write(d, 1);
      end
      lbrb_pkg::OP_MSG: begin
        if (first) begin
          msg_kept = room_write(d, int'(len));
          acc = msg_kept;
        end else if (msg_kept) begin
          if (held_now() < DEPTH) begin
            append(d);
            acc = 1'b1;
          end else begin
            msg_kept = 1'b0;
          end
        end
      end
      lbrb_pkg::OP_READ, lbrb_pkg::OP_READ_CRLF: begin
        if (held_now() != 0) begin
          // full ring: oldest byte is dropped first
          if (held_now() >= DEPTH) rd_ptr = rd_ptr + 1'b1;
          c = ring_mem[rd_ptr[LOGD-1:0]];
          rd_ptr = rd_ptr + 1'b1;
          if (op == lbrb_pkg::OP_READ_CRLF && c == lbrb_pkg::CHAR_LF)
            push(lbrb_pkg::CHAR_CR, 1'b1, 1'b0, 1'b0);
          push(c, 1'b1, 1'b1, 1'b0);
          return;
        end
      end
      lbrb_pkg::OP_PEEK: begin
        peek_at = 32'(wr_ptr) - 32'(off);
        push(ring_mem[peek_at[LOGD-1:0]], 1'b1, 1'b1, 1'b0);
        return;
      end
      lbrb_pkg::OP_CLEAR: wipe();
      default: ;
    endcase
    push('0, 1'b0, 1'b1, acc);
  endfunction

  task report(string what, longint got, longint want);
    if (errors < 100) $display("mismatch %0d: %s got 'h%0h, due 'h%0h", errors, what, got, want);
    errors++;
  endtask

  task check_result(lbrb_pkg::byte_t d, logic v, logic t, logic [LOGD:0] h,
                    lbrb_pkg::count_t o, logic a);
    ring_result_t e;
    if (due_results.size() == 0) begin
      report("result with nothing due", d, 0);
      return;
    end
    e = due_results.pop_front();
    if (d !== e.data)      report("read_data", d, e.data);
    if (v !== e.valid)     report("read_valid", v, e.valid);
    if (t !== e.tail)      report("last", t, e.tail);
    if (h !== e.held)      report("held_bytes", h, e.held);
    if (o !== e.overflows) report("overflow_total", o, e.overflows);
    if (a !== e.accepted)  report("write_accepted", a, e.accepted);
  endtask
endclass

module log_byte_ring_buffer_tb;
  localparam int            RING_LOG    = 10;
  localparam int            RING_DEPTH  = 1 << RING_LOG;
  localparam lbrb_pkg::op_t OP_SPARE_LO = 3'd6;
  localparam lbrb_pkg::op_t OP_SPARE_HI = 3'd7;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_FULL} mix_t;

  logic             clk              = 1'b0;
  logic             rst              = 1'b1;
  logic             start            = 1'b0;
  lbrb_pkg::op_t    operation        = lbrb_pkg::OP_PUT;
  lbrb_pkg::byte_t  write_data       = '0;
  logic             first_of_message = 1'b0;
  lbrb_pkg::len_t   message_length   = '0;
  lbrb_pkg::level_t current_level    = '0;
  lbrb_pkg::len_t   history_offset   = '0;
  logic             cfg_write        = 1'b0;
  lbrb_pkg::level_t cfg_data         = '0;

  logic              busy;
  logic              result_strobe;
  lbrb_pkg::byte_t   read_data;
  logic              read_valid;
  logic              last;
  logic [RING_LOG:0] held_bytes;
  lbrb_pkg::count_t  overflow_total;
  logic              write_accepted;

  ring_shadow #(RING_LOG) shadow;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned gap_max    = 0;

  log_byte_ring_buffer #(.LOG_DEPTH(RING_LOG)) u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .operation        (operation),
    .write_data       (write_data),
    .first_of_message (first_of_message),
    .message_length   (message_length),
    .current_level    (current_level),
    .history_offset   (history_offset),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .result_strobe    (result_strobe),
    .read_data        (read_data),
    .read_valid       (read_valid),
    .last             (last),
    .held_bytes       (held_bytes),
    .overflow_total   (overflow_total),
    .write_accepted   (write_accepted)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe)
        shadow.check_result(read_data, read_valid, last, held_bytes, overflow_total,
                            write_accepted);
      if (cfg_write) shadow.set_threshold(cfg_data);
      if (start && !busy)
        shadow.take_item(operation, write_data, first_of_message, message_length,
                         current_level, history_offset);
    end
  end

  function automatic lbrb_pkg::byte_t pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return lbrb_pkg::CHAR_LF;
    if (r < 20) return lbrb_pkg::MARKER;
    if (r < 25) return 8'h00;
    return lbrb_pkg::byte_t'($urandom);
  endfunction

  function automatic lbrb_pkg::len_t pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return lbrb_pkg::len_t'($urandom_range(1, 64));
    if (r < 80) return lbrb_pkg::len_t'($urandom_range(1, RING_DEPTH));
    return lbrb_pkg::len_t'($urandom_range(0, 2047));
  endfunction

  task automatic hold(int unsigned n);
    start            <= 1'b0;
    operation        <= lbrb_pkg::op_t'($urandom);
    write_data       <= lbrb_pkg::byte_t'($urandom);
    first_of_message <= 1'($urandom);
    message_length   <= lbrb_pkg::len_t'($urandom);
    current_level    <= lbrb_pkg::level_t'($urandom);
    history_offset   <= lbrb_pkg::len_t'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if (gap_max > 0) hold($urandom_range(1, gap_max));
    end
  endtask

  task automatic send(lbrb_pkg::op_t op, lbrb_pkg::byte_t d, logic first,
                      lbrb_pkg::len_t len, lbrb_pkg::level_t lv, lbrb_pkg::len_t off);
    start            <= 1'b1;
    operation        <= op;
    write_data       <= d;
    first_of_message <= first;
    message_length   <= len;
    current_level    <= lv;
    history_offset   <= off;
    do @(posedge clk); while (busy);
    items_sent++;
    pace();
  endtask

  task automatic send_op(lbrb_pkg::op_t op);
    send(op, pick_byte(), 1'($urandom), lbrb_pkg::len_t'($urandom),
         lbrb_pkg::level_t'($urandom), pick_offset());
  endtask

  task automatic message(int len, int nbytes);
    send(lbrb_pkg::OP_MSG, pick_byte(), 1'b1, lbrb_pkg::len_t'(len),
         lbrb_pkg::level_t'($urandom), lbrb_pkg::len_t'($urandom));
    for (int i = 1; i < nbytes; i++)
      send(lbrb_pkg::OP_MSG, pick_byte(), 1'b0, lbrb_pkg::len_t'($urandom),
           lbrb_pkg::level_t'($urandom), lbrb_pkg::len_t'($urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_level(lbrb_pkg::level_t v);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic put_random();
    send(lbrb_pkg::OP_PUT, pick_byte(), 1'($urandom), lbrb_pkg::len_t'($urandom),
         lbrb_pkg::level_t'($urandom), pick_offset());
  endtask

  task automatic noise();
    int len;
    case ($urandom_range(0, 3))
      0: send_op(OP_SPARE_LO);
      1: send_op(OP_SPARE_HI);
      2: send(lbrb_pkg::OP_MSG, pick_byte(), 1'b0, lbrb_pkg::len_t'($urandom),
              lbrb_pkg::level_t'($urandom), pick_offset());
      default: begin
        len = $urandom_range(0, 2047);
        message(len, $urandom_range(1, 4));
      end
    endcase
  endtask

  task automatic random_step(mix_t mix);
    int r;
    int len;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 40) put_random();
        else if (r < 85) begin
          len = $urandom_range(1, 48);
          message(len, len);
        end
        else if (r < 90) send_op(lbrb_pkg::OP_READ);
        else if (r < 93) send_op(lbrb_pkg::OP_READ_CRLF);
        else if (r < 98) send_op(lbrb_pkg::OP_PEEK);
        else noise();
      end
      MIX_FULL: begin
        len = $urandom_range(1, 8);
        if (r < 25) put_random();
        else if (r < 35) message(len, len);
        // message running past its stated length
        else if (r < 45) message(len, len + $urandom_range(1, 6));
        else if (r < 60) send_op(lbrb_pkg::OP_READ);
        else if (r < 75) send_op(lbrb_pkg::OP_READ_CRLF);
        else if (r < 90) send_op(lbrb_pkg::OP_PEEK);
        else noise();
      end
      default: begin
        len = $urandom_range(1, 8);
        if (r < 22) put_random();
        else if (r < 36) message(len, len);
        else if (r < 40) message(len, $urandom_range(1, len));
        else if (r < 58) send_op(lbrb_pkg::OP_READ);
        else if (r < 78) send_op(lbrb_pkg::OP_READ_CRLF);
        else if (r < 91) send_op(lbrb_pkg::OP_PEEK);
        else if (r < 92) send_op(lbrb_pkg::OP_CLEAR);
        else if (r < 94) drain();
        else noise();
      end
    endcase
  endtask

  task automatic run_mix(mix_t mix, int unsigned n);
    int unsigned goal;
    goal = items_sent + n;
    while (items_sent < goal) random_step(mix);
  endtask

  initial begin
    shadow = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_level(4'd0);
    gap_max = 3;

    send(lbrb_pkg::OP_READ,      8'h00, 1'b0, 11'd1,   4'd0,  11'd1);
    send(lbrb_pkg::OP_READ_CRLF, 8'hFF, 1'b1, 11'd1,   4'd15, 11'd1);
    send(lbrb_pkg::OP_PEEK,      8'h00, 1'b0, 11'd1,   4'd0,  11'd0);
    send(lbrb_pkg::OP_PUT,       8'h41, 1'b0, 11'd1,   4'd0,  11'd0);
    send(lbrb_pkg::OP_PUT,       lbrb_pkg::CHAR_LF, 1'b1, 11'h7FF, 4'd15, 11'h7FF);
    send(lbrb_pkg::OP_PUT,       8'h00, 1'b0, 11'd1,   4'd3,  11'd0);
    send(lbrb_pkg::OP_PUT,       8'hFF, 1'b0, 11'd1,   4'd8,  11'd0);
    send(lbrb_pkg::OP_MSG,       8'h68, 1'b1, 11'd3,   4'd0,  11'd0);
    send(lbrb_pkg::OP_MSG,       8'h69, 1'b0, 11'd0,   4'd0,  11'd0);
    send(lbrb_pkg::OP_MSG,       lbrb_pkg::CHAR_LF, 1'b0, 11'd0, 4'd0, 11'd0);
    send(lbrb_pkg::OP_MSG,       8'h55, 1'b1, 11'd0,   4'd0,  11'd0);
    send(lbrb_pkg::OP_MSG,       8'hAA, 1'b0, 11'h7FF, 4'd15, 11'h7FF);
    send(lbrb_pkg::OP_MSG,       8'h5A, 1'b1, 11'h7FF, 4'd0,  11'd0);
    send(lbrb_pkg::OP_MSG,       8'hA5, 1'b0, 11'd1,   4'd0,  11'd0);
    send(lbrb_pkg::OP_PEEK,      8'h00, 1'b0, 11'd1,   4'd0,  11'd1);
    send(lbrb_pkg::OP_PEEK,      8'h00, 1'b0, 11'd1,   4'd0,  11'd1024);
    send(lbrb_pkg::OP_PEEK,      8'h00, 1'b0, 11'd1,   4'd0,  11'h7FF);
    send(lbrb_pkg::OP_READ_CRLF, 8'h00, 1'b0, 11'd1,   4'd0,  11'd1);
    send(lbrb_pkg::OP_READ_CRLF, 8'h00, 1'b0, 11'd1,   4'd0,  11'd1);
    send(lbrb_pkg::OP_READ,      8'h00, 1'b0, 11'd1,   4'd0,  11'd1);
    send(OP_SPARE_LO,            8'h00, 1'b0, 11'd1,   4'd0,  11'd1);
    send(OP_SPARE_HI,            8'hFF, 1'b1, 11'h7FF, 4'd15, 11'h7FF);
    send(lbrb_pkg::OP_CLEAR,     8'h00, 1'b0, 11'd1,   4'd0,  11'd1);
    set_level(4'd15);
    send(lbrb_pkg::OP_PUT,       8'h42, 1'b0, 11'd1,   4'd14, 11'd0);
    send(lbrb_pkg::OP_PUT,       8'h43, 1'b0, 11'd1,   4'd15, 11'd0);

    set_level(lbrb_pkg::level_t'($urandom_range(1, 14)));
    gap_max = 6;
    run_mix(MIX_BALANCED, 180);

    // fill to the brim with no idling, then work around a full ring
    set_level(4'd0);
    send_op(lbrb_pkg::OP_CLEAR);
    gap_max = 0;
    while (shadow.held_now() < RING_DEPTH && items_sent < 1500) random_step(MIX_FILL);
    gap_max = 4;
    run_mix(MIX_FULL, 110);

    set_level(4'd15);
    gap_max = 8;
    run_mix(MIX_BALANCED, 80);

    drain();
    repeat (8) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #6000000;
    $display("FAIL");
    $finish;
  end
endmodule

// ===== log_byte_ring_buffer.f =====
+incdir+rtl
rtl/lbrb_pkg.sv
rtl/log_byte_ring_buffer.sv
rtl/lbrb_checker.sv
tb/log_byte_ring_buffer_tb.sv
